@@ rtl/fpma_pkg.sv @@
// Shared types, constants and the control store for the flash page map allocator.
// Depends on nothing; every other file imports it.
package fpma_pkg;

    // Request field widths (fixed by the interface)
    localparam int VB_W   = 2;
    localparam int VP_W   = 2;
    localparam int VIDX_W = VB_W + VP_W;
    localparam int OUT_W  = 2;

    // Default geometry
    localparam int DEF_BLOCK_COUNT    = 4;
    localparam int DEF_PAGES_IN_BLOCK = 4;

    // Physical page states
    typedef enum logic [1:0] {
        PS_AVAILABLE = 2'd0,
        PS_IN_USE    = 2'd1,
        PS_INVALID   = 2'd2
    } t_pstat;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_RD_OLD,
        OP_INVAL,
        OP_SCAN_BLK_INIT,
        OP_SCAN,
        OP_ERASE_INIT,
        OP_ERASE,
        OP_SCAN_FREE_INIT,
        OP_ALLOC,
        OP_NOSPACE,
        OP_RESULT
    } t_dp_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_SKIP_WRITE,
        C_OLD_UNMAPPED,
        C_OLD_NOT_USED,
        C_CLR_MORE,
        C_SCAN_BUSY,
        C_SCAN_HIT,
        C_NO_HIT,
        C_ERASE_MORE
    } t_cond;

    localparam int UW = 4;

    // Program steps
    localparam logic [UW-1:0] S_CLR        = 4'd0;
    localparam logic [UW-1:0] S_IDLE       = 4'd1;
    localparam logic [UW-1:0] S_DISPATCH   = 4'd2;
    localparam logic [UW-1:0] S_RD_OLD     = 4'd3;
    localparam logic [UW-1:0] S_CHK_OLD    = 4'd4;
    localparam logic [UW-1:0] S_INVAL      = 4'd5;
    localparam logic [UW-1:0] S_BLK_INIT   = 4'd6;
    localparam logic [UW-1:0] S_BLK_SCAN   = 4'd7;
    localparam logic [UW-1:0] S_BLK_DEC    = 4'd8;
    localparam logic [UW-1:0] S_ERASE      = 4'd9;
    localparam logic [UW-1:0] S_FREE_INIT  = 4'd10;
    localparam logic [UW-1:0] S_FREE_SCAN  = 4'd11;
    localparam logic [UW-1:0] S_FREE_DEC   = 4'd12;
    localparam logic [UW-1:0] S_ALLOC      = 4'd13;
    localparam logic [UW-1:0] S_NOSPACE    = 4'd14;
    localparam logic [UW-1:0] S_RESULT     = 4'd15;

    typedef struct packed {
        t_dp_op        op;
        t_cond         cond;
        logic [UW-1:0] target;
    } t_uword;

    // Condition inputs from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic skip_write;
        logic old_unmapped;
        logic old_not_used;
        logic clr_more;
        logic scan_busy;
        logic scan_hit;
        logic erase_more;
    } t_flags;

    // Control store
    function automatic t_uword f_ucode(input logic [UW-1:0] step);
        t_uword w;
        w = '{OP_NOP, C_NEXT, S_IDLE};
        case (step)
            S_CLR:       w = '{OP_CLR,            C_CLR_MORE,     S_CLR};
            S_IDLE:      w = '{OP_NOP,            C_NO_START,     S_IDLE};
            S_DISPATCH:  w = '{OP_NOP,            C_SKIP_WRITE,   S_RESULT};
            S_RD_OLD:    w = '{OP_RD_OLD,         C_OLD_UNMAPPED, S_FREE_INIT};
            S_CHK_OLD:   w = '{OP_NOP,            C_OLD_NOT_USED, S_FREE_INIT};
            S_INVAL:     w = '{OP_INVAL,          C_NEXT,         S_IDLE};
            S_BLK_INIT:  w = '{OP_SCAN_BLK_INIT,  C_NEXT,         S_IDLE};
            S_BLK_SCAN:  w = '{OP_SCAN,           C_SCAN_BUSY,    S_BLK_SCAN};
            S_BLK_DEC:   w = '{OP_ERASE_INIT,     C_SCAN_HIT,     S_FREE_INIT};
            S_ERASE:     w = '{OP_ERASE,          C_ERASE_MORE,   S_ERASE};
            S_FREE_INIT: w = '{OP_SCAN_FREE_INIT, C_NEXT,         S_IDLE};
            S_FREE_SCAN: w = '{OP_SCAN,           C_SCAN_BUSY,    S_FREE_SCAN};
            S_FREE_DEC:  w = '{OP_NOP,            C_NO_HIT,       S_NOSPACE};
            S_ALLOC:     w = '{OP_ALLOC,          C_ALWAYS,       S_RESULT};
            S_NOSPACE:   w = '{OP_NOSPACE,        C_NEXT,         S_IDLE};
            S_RESULT:    w = '{OP_RESULT,         C_ALWAYS,       S_IDLE};
            default:     w = '{OP_NOP,            C_ALWAYS,       S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fpma_status_ram.sv @@
// Page state memory: one write port, one read port with registered read data.
// Depends on fpma_pkg for the page state type.
module fpma_status_ram import fpma_pkg::*; #(
    parameter int DEPTH = DEF_BLOCK_COUNT * DEF_PAGES_IN_BLOCK
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_pstat                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_pstat                   o_rdata
);

    t_pstat r_mem [DEPTH];
    t_pstat r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fpma_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fpma_pkg for the control word, conditions and program.
module fpma_useq import fpma_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_dp_op o_op,
    output logic   o_idle
);

    logic [UW-1:0] r_upc;
    logic [UW-1:0] n_upc;
    t_uword        w_word;
    logic          w_take;

    always_comb begin
        w_word = f_ucode(r_upc);
        case (w_word.cond)
            C_NEXT:         w_take = 1'b0;
            C_ALWAYS:       w_take = 1'b1;
            C_NO_START:     w_take = !i_flags.start;
            C_SKIP_WRITE:   w_take = i_flags.skip_write;
            C_OLD_UNMAPPED: w_take = i_flags.old_unmapped;
            C_OLD_NOT_USED: w_take = i_flags.old_not_used;
            C_CLR_MORE:     w_take = i_flags.clr_more;
            C_SCAN_BUSY:    w_take = i_flags.scan_busy;
            C_SCAN_HIT:     w_take = i_flags.scan_hit;
            C_NO_HIT:       w_take = !i_flags.scan_hit;
            C_ERASE_MORE:   w_take = i_flags.erase_more;
            default:        w_take = 1'b0;
        endcase
        n_upc = w_take ? w_word.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op   = w_word.op;
    assign o_idle = (r_upc == S_IDLE);

endmodule

@@ rtl/flash_page_map_allocator.sv @@
// Flash page map allocator. Lookup: dispatch step, result step, then the registered result strobe.
// Write: walks the page state memory one page a cycle, with no stall, in its passes
// (block check, erase sweep, free-page search) before the result step.
// Throughput: one request at a time; busy drops in the cycle that carries the result beat.
// Reset: the map is unmapped at once; a clearing pass over all TOTAL = BLOCK_COUNT*PAGES_IN_BLOCK
// pages then marks every page available while busy stays high. The receiver cannot stall.
module flash_page_map_allocator import fpma_pkg::*; #(
    parameter int BLOCK_COUNT    = DEF_BLOCK_COUNT,
    parameter int PAGES_IN_BLOCK = DEF_PAGES_IN_BLOCK
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_action,
    input  logic [VB_W-1:0]  i_virtual_block,
    input  logic [VP_W-1:0]  i_virtual_page,
    output logic             o_done,
    output logic [OUT_W-1:0] o_physical_block,
    output logic [OUT_W-1:0] o_physical_page,
    output logic             o_mapped,
    output logic             o_no_space,
    output logic             o_erased,
    output logic [OUT_W-1:0] o_erased_block
);

    localparam int TOTAL = BLOCK_COUNT * PAGES_IN_BLOCK;
    localparam int AW    = $clog2(TOTAL);
    localparam int AW1   = $clog2(TOTAL + 1);
    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int PW    = (PAGES_IN_BLOCK > 1) ? $clog2(PAGES_IN_BLOCK) : 1;
    localparam int VDEPTH = 2 ** VIDX_W;

    // Sequencer interface
    t_dp_op w_op;
    logic   w_idle;
    t_flags w_flags;

    // Captured request
    logic              r_write;
    logic              r_in_range;
    logic [VIDX_W-1:0] r_vidx;

    // Map table: valid bits in reset flops, address fields as plain registers.
    // Only the sixteen addressable virtual pages ever get an entry.
    logic          r_map_vld [VDEPTH];
    logic [BW-1:0] r_map_blk [VDEPTH];
    logic [PW-1:0] r_map_pg  [VDEPTH];

    // Scan and sweep engine
    logic [AW1-1:0] r_ia;
    logic [AW1-1:0] r_end;
    logic [BW-1:0]  r_ib;
    logic [PW-1:0]  r_ip;
    logic           r_scan_free;
    logic           r_chk_vld;
    logic [AW-1:0]  r_chk_addr;
    logic [BW-1:0]  r_chk_blk;
    logic [PW-1:0]  r_chk_pg;
    logic           r_hit;
    logic [AW-1:0]  r_hit_addr;
    logic [BW-1:0]  r_hit_blk;
    logic [PW-1:0]  r_hit_pg;

    // Result flags
    logic          r_no_space;
    logic          r_erased;
    logic [BW-1:0] r_erased_blk;

    // Result beat registers
    logic             r_done;
    logic [OUT_W-1:0] r_out_blk;
    logic [OUT_W-1:0] r_out_pg;
    logic             r_out_mapped;
    logic             r_out_no_space;
    logic             r_out_erased;
    logic [OUT_W-1:0] r_out_eblk;

    // Memory ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_pstat        w_wdata;
    logic [AW-1:0] w_raddr;
    t_pstat        w_rdata;

    // Derived datapath values
    logic           w_accept;
    logic           w_in_range;
    logic [BW-1:0]  w_old_blk;
    logic [PW-1:0]  w_old_pg;
    logic [AW1-1:0] w_old_base;
    logic [AW1-1:0] w_old_addr;
    logic           w_issuing;
    logic           w_match;
    logic           w_hit_now;
    logic           w_scan_done;
    logic           w_cur_mapped;

    fpma_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op),
        .o_idle  (w_idle)
    );

    fpma_status_ram #(
        .DEPTH (TOTAL)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = !w_idle;
    assign w_accept = start && w_idle;

    assign w_in_range = (32'(i_virtual_block) < BLOCK_COUNT) &&
                        (32'(i_virtual_page) < PAGES_IN_BLOCK);

    // Old physical page of the captured virtual page
    assign w_old_blk  = r_map_blk[r_vidx];
    assign w_old_pg   = r_map_pg[r_vidx];
    assign w_old_base = AW1'(w_old_blk) * AW1'(PAGES_IN_BLOCK);
    assign w_old_addr = w_old_base + AW1'(w_old_pg);

    // Scan: issue one read a cycle until a hit or the range end, check the returned state in the cycle after.
    // Block mode stops on a page that is not invalid; free mode on an available page.
    assign w_issuing   = (r_ia != r_end) && !r_hit;
    assign w_match     = r_scan_free ? (w_rdata == PS_AVAILABLE) : (w_rdata != PS_INVALID);
    assign w_hit_now   = r_chk_vld && w_match;
    assign w_scan_done = w_hit_now || r_hit || (!w_issuing && !r_chk_vld);

    assign w_cur_mapped = r_in_range && r_map_vld[r_vidx];

    always_comb begin
        w_flags.start        = start;
        w_flags.skip_write   = !r_write || !r_in_range;
        w_flags.old_unmapped = !r_map_vld[r_vidx];
        w_flags.old_not_used = (w_rdata != PS_IN_USE);
        w_flags.clr_more     = (r_ia != AW1'(TOTAL - 1));
        w_flags.scan_busy    = !w_scan_done;
        w_flags.scan_hit     = r_hit;
        w_flags.erase_more   = (r_ip != PW'(PAGES_IN_BLOCK - 1));
    end

    // Memory port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ia[AW-1:0];
        w_wdata = PS_AVAILABLE;
        case (w_op)
            OP_CLR, OP_ERASE: begin
                w_we = 1'b1;
            end
            OP_INVAL: begin
                w_we    = 1'b1;
                w_waddr = w_old_addr[AW-1:0];
                w_wdata = PS_INVALID;
            end
            OP_ALLOC: begin
                w_we    = 1'b1;
                w_waddr = r_hit_addr;
                w_wdata = PS_IN_USE;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        w_raddr = (w_op == OP_RD_OLD) ? w_old_addr[AW-1:0] : r_ia[AW-1:0];
    end

    // Control state: sweep/scan counters, hit tracking, flags, map valid bits, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ia        <= '0;
            r_end       <= '0;
            r_ip        <= '0;
            r_scan_free <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_no_space  <= 1'b0;
            r_erased    <= 1'b0;
            r_write     <= 1'b0;
            r_in_range  <= 1'b0;
            r_done      <= 1'b0;
            for (int i = 0; i < VDEPTH; i++) begin
                r_map_vld[i] <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
            if (w_accept) begin
                r_write    <= i_action;
                r_in_range <= w_in_range;
                r_no_space <= 1'b0;
                r_erased   <= 1'b0;
            end
            case (w_op)
                OP_CLR: begin
                    r_ia <= r_ia + 1'b1;
                end
                OP_SCAN_BLK_INIT: begin
                    r_ia        <= w_old_base;
                    r_end       <= w_old_base + AW1'(PAGES_IN_BLOCK);
                    r_ip        <= '0;
                    r_scan_free <= 1'b0;
                    r_chk_vld   <= 1'b0;
                    r_hit       <= 1'b0;
                end
                OP_SCAN_FREE_INIT: begin
                    r_ia        <= '0;
                    r_end       <= AW1'(TOTAL);
                    r_ip        <= '0;
                    r_scan_free <= 1'b1;
                    r_chk_vld   <= 1'b0;
                    r_hit       <= 1'b0;
                    // drop the old mapping before allocating
                    r_map_vld[r_vidx] <= 1'b0;
                end
                OP_SCAN: begin
                    r_chk_vld <= w_issuing;
                    if (w_issuing) begin
                        r_ia <= r_ia + 1'b1;
                        r_ip <= (r_ip == PW'(PAGES_IN_BLOCK - 1)) ? '0 : r_ip + 1'b1;
                    end
                    if (w_hit_now) begin
                        r_hit <= 1'b1;
                    end
                end
                OP_ERASE_INIT: begin
                    r_ia <= w_old_base;
                    r_ip <= '0;
                end
                OP_ERASE: begin
                    r_ia     <= r_ia + 1'b1;
                    r_ip     <= r_ip + 1'b1;
                    r_erased <= 1'b1;
                end
                OP_ALLOC: begin
                    r_map_vld[r_vidx] <= 1'b1;
                end
                OP_NOSPACE: begin
                    r_no_space <= 1'b1;
                end
                OP_RESULT: begin
                    r_done <= 1'b1;
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    // Payload: captured address, block counter, hit location, map fields, result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vidx       <= {i_virtual_block, i_virtual_page};
            r_erased_blk <= '0;
        end
        case (w_op)
            OP_SCAN_BLK_INIT: begin
                r_ib <= w_old_blk;
            end
            OP_SCAN_FREE_INIT: begin
                r_ib <= '0;
            end
            OP_SCAN: begin
                if (w_issuing) begin
                    r_chk_addr <= r_ia[AW-1:0];
                    r_chk_blk  <= r_ib;
                    r_chk_pg   <= r_ip;
                    if (r_ip == PW'(PAGES_IN_BLOCK - 1)) begin
                        r_ib <= r_ib + 1'b1;
                    end
                end
                if (w_hit_now) begin
                    r_hit_addr <= r_chk_addr;
                    r_hit_blk  <= r_chk_blk;
                    r_hit_pg   <= r_chk_pg;
                end
            end
            OP_ERASE: begin
                r_erased_blk <= w_old_blk;
            end
            OP_ALLOC: begin
                r_map_blk[r_vidx] <= r_hit_blk;
                r_map_pg[r_vidx]  <= r_hit_pg;
            end
            OP_RESULT: begin
                r_out_blk      <= w_cur_mapped ? OUT_W'(w_old_blk) : '0;
                r_out_pg       <= w_cur_mapped ? OUT_W'(w_old_pg) : '0;
                r_out_mapped   <= w_cur_mapped;
                r_out_no_space <= r_no_space;
                r_out_erased   <= r_erased;
                r_out_eblk     <= r_erased ? OUT_W'(r_erased_blk) : '0;
            end
            default: begin
                r_out_mapped <= r_out_mapped;
            end
        endcase
    end

    assign o_done           = r_done;
    assign o_physical_block = r_out_blk;
    assign o_physical_page  = r_out_pg;
    assign o_mapped         = r_out_mapped;
    assign o_no_space       = r_out_no_space;
    assign o_erased         = r_out_erased;
    assign o_erased_block   = r_out_eblk;

endmodule
